[hw/rtl/fsp_pkg.sv]
package fsp_pkg;

  localparam int unsigned FLASH_BYTES  = 65536;
  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned SECTOR_COUNT = 16;

  localparam int unsigned SEC_W     = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
  localparam int unsigned SEC_SHIFT = $clog2(SECTOR_BYTES);
  localparam int unsigned PAGE_SHIFT = 8;
  localparam int unsigned PG2SEC_SHIFT = SEC_SHIFT - PAGE_SHIFT;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] PART_ID_WORD  = 32'h0005_0080;
  localparam logic [31:0] BOOT_VER_WORD = 32'h0001_0000;

  localparam logic [2:0] ACT_PREPARE     = 3'd0;
  localparam logic [2:0] ACT_WRITE       = 3'd1;
  localparam logic [2:0] ACT_ERASE_SECT  = 3'd2;
  localparam logic [2:0] ACT_ERASE_PAGES = 3'd3;
  localparam logic [2:0] ACT_PART_ID     = 3'd4;
  localparam logic [2:0] ACT_BOOT_VER    = 3'd5;
  localparam logic [2:0] ACT_REINVOKE    = 3'd6;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_CMD    = 3'd1;
  localparam logic [2:0] ST_BAD_SECTOR = 3'd2;
  localparam logic [2:0] ST_COUNT      = 3'd3;
  localparam logic [2:0] ST_ALIGN      = 3'd4;
  localparam logic [2:0] ST_UNMAPPED   = 3'd5;
  localparam logic [2:0] ST_NOT_PREP   = 3'd6;

  localparam logic [1:0] GK_NONE  = 2'd0;
  localparam logic [1:0] GK_WRITE = 2'd1;
  localparam logic [1:0] GK_ERASE = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_PREP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_ERASE = 3'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [2:0]       status;
    logic [SEC_W-1:0] lo;
    logic [SEC_W-1:0] hi;
    logic             force_np;
    logic [31:0]      info;
    logic [1:0]       gkind;
    logic [15:0]      gofs;
    logic [16:0]      glen;
    logic [31:0]      gsrc;
  } cmd_t;

endpackage

[hw/rtl/fsp_front.sv]
module fsp_front
  import fsp_pkg::*;
(
  input  logic [2:0]  action,
  input  logic [31:0] first_value,
  input  logic [31:0] second_value,
  input  logic [31:0] byte_count,
  input  logic [31:0] source_address,
  output cmd_t        cmd
);

  logic [32:0] end_addr;
  logic [32:0] last_addr;
  logic [32:0] hi_full;
  logic [31:0] lo_full;
  logic        cnt_ok;
  logic        bound_bad;
  logic [31:0] ra;
  logic [31:0] rb;
  logic        range_ok;
  logic [SEC_W-1:0] rlo;
  logic [SEC_W-1:0] rhi;
  logic [SEC_W:0]   nsec;
  logic [32:0] eofs;
  logic [32:0] elen;

  always_comb begin
    end_addr  = {1'b0, first_value} + {1'b0, byte_count};
    last_addr = end_addr - 33'd1;
    hi_full   = last_addr >> SEC_SHIFT;
    lo_full   = first_value >> SEC_SHIFT;
    cnt_ok    = (byte_count == 32'd256) || (byte_count == 32'd512) ||
                (byte_count == 32'd1024) || (byte_count == 32'd4096);
    bound_bad = end_addr > 33'(FLASH_BYTES);

    if (action == ACT_ERASE_PAGES) begin
      ra = first_value >> PG2SEC_SHIFT;
      rb = second_value >> PG2SEC_SHIFT;
    end else begin
      ra = first_value;
      rb = second_value;
    end
    range_ok = (ra < 32'(SECTOR_COUNT)) && (rb < 32'(SECTOR_COUNT)) && (ra <= rb);
    rlo  = ra[SEC_W-1:0];
    rhi  = rb[SEC_W-1:0];
    nsec = {1'b0, rhi} - {1'b0, rlo} + {{SEC_W{1'b0}}, 1'b1};
    eofs = 33'(rlo) << SEC_SHIFT;
    elen = 33'(nsec) << SEC_SHIFT;

    cmd = '0;
    cmd.op     = OP_NOP;
    cmd.status = ST_OK;
    cmd.lo     = rlo;
    cmd.hi     = rhi;

    case (action)
      ACT_PREPARE: begin
        cmd.op = OP_PREP;
        if (!range_ok) begin
          cmd.status = ST_BAD_SECTOR;
        end
      end
      ACT_WRITE: begin
        cmd.op = OP_WRITE;
        if (!cnt_ok) begin
          cmd.status = ST_COUNT;
        end else if (first_value[7:0] != 8'd0) begin
          cmd.status = ST_ALIGN;
        end else if (bound_bad) begin
          cmd.status = ST_UNMAPPED;
        end else begin
          cmd.lo       = lo_full[SEC_W-1:0];
          cmd.hi       = hi_full[SEC_W-1:0];
          cmd.force_np = (hi_full >= 33'(SECTOR_COUNT));
          cmd.gkind    = GK_WRITE;
          cmd.gofs     = first_value[15:0];
          cmd.glen     = byte_count[16:0];
          cmd.gsrc     = source_address;
        end
      end
      ACT_ERASE_SECT, ACT_ERASE_PAGES: begin
        cmd.op = OP_ERASE;
        if (!range_ok) begin
          cmd.status = ST_BAD_SECTOR;
        end else begin
          cmd.gkind = GK_ERASE;
          cmd.gofs  = eofs[15:0];
          cmd.glen  = elen[16:0];
        end
      end
      ACT_PART_ID: begin
        cmd.info = PART_ID_WORD;
      end
      ACT_BOOT_VER: begin
        cmd.info = BOOT_VER_WORD;
      end
      ACT_REINVOKE: begin
        cmd.op = OP_NOP;
      end
      default: begin
        cmd.status = ST_BAD_CMD;
      end
    endcase
  end

endmodule

[hw/rtl/fsp_queue.sv]
module fsp_queue
  import fsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic full,
  output logic not_empty
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/fsp_back.sv]
module fsp_back
  import fsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_info_word,
  output logic [1:0]  out_grant_kind,
  output logic [15:0] out_grant_offset,
  output logic [16:0] out_grant_length,
  output logic [31:0] out_grant_source
);

  localparam logic [SECTOR_COUNT-1:0] ALL_ONES = '1;

  logic [SECTOR_COUNT-1:0] prep_r;
  logic [SECTOR_COUNT-1:0] prep_nxt;
  logic [SECTOR_COUNT-1:0] rmask;
  logic                    ready_ok;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [2:0]              out_status_r;
  logic [31:0]             out_info_r;
  logic [1:0]              out_gkind_r;
  logic [15:0]             out_gofs_r;
  logic [16:0]             out_glen_r;
  logic [31:0]             out_gsrc_r;
  cmd_t                    res;

  assign cmd_pop = cmd_valid && (!out_valid_r || out_ready);

  always_comb begin
    rmask    = (ALL_ONES << cmd.lo) &
               (ALL_ONES >> (SEC_W'(SECTOR_COUNT - 1) - cmd.hi));
    ready_ok = ((prep_r & rmask) == rmask) && !cmd.force_np;
    res      = cmd;
    prep_nxt = prep_r;
    if (cmd.status == ST_OK) begin
      case (cmd.op)
        OP_PREP: begin
          prep_nxt = prep_r | rmask;
        end
        OP_WRITE, OP_ERASE: begin
          if (ready_ok) begin
            prep_nxt = prep_r & ~rmask;
          end else begin
            res        = '0;
            res.status = ST_NOT_PREP;
          end
        end
        OP_NOP: begin
          prep_nxt = prep_r;
        end
        default: begin
          prep_nxt = prep_r;
        end
      endcase
    end
    if (cmd_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd_pop) begin
        prep_r <= prep_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      out_status_r <= res.status;
      out_info_r   <= res.info;
      out_gkind_r  <= res.gkind;
      out_gofs_r   <= res.gofs;
      out_glen_r   <= res.glen;
      out_gsrc_r   <= res.gsrc;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_info_word    = out_info_r;
  assign out_grant_kind   = out_gkind_r;
  assign out_grant_offset = out_gofs_r;
  assign out_grant_length = out_glen_r;
  assign out_grant_source = out_gsrc_r;

  // failed commands carry no grant and no info
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |->
      (out_gkind_r == GK_NONE) && (out_glen_r == '0) && (out_info_r == '0))
    else $error("failed word carries payload");

  // a grant always has a length and an ok status
  a_grant_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_gkind_r != GK_NONE) |->
      (out_glen_r != '0) && (out_status_r == ST_OK))
    else $error("grant without length");

  // sector mask only moves when a word is taken from the queue
  a_mask_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_pop |=> $stable(prep_r))
    else $error("sector mask changed without a word");

  // a granted operation leaves its sectors unprepared
  a_grant_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && (cmd.status == ST_OK) && (cmd.op == OP_WRITE || cmd.op == OP_ERASE) &&
      ready_ok |=> ((prep_r & $past(rmask)) == '0))
    else $error("granted sectors still prepared");

endmodule

[hw/rtl/flash_sector_prepare_guard.sv]
// Command guard of an in-application flash programmer.
// Input channel in_valid/in_ready carries one command word: action, first_value,
// second_value, byte_count, source_address. Output channel out_valid/out_ready
// returns exactly one result word per command: status, info_word and the grant
// (kind, offset, length, source) that a flash engine then carries out.
// A decoder classifies each command (count, alignment, bound and range checks)
// and pushes it into a two-entry queue; a back stage checks the prepared-sector
// mask, updates it and loads the output register.
// An accepted command is written into the queue, and the back stage then takes it
// into the output register. Throughput: one command per cycle while out_ready
// stays high; the back stage checks and updates the mask as it takes each command.
// Reset (rst_n low, synchronous) clears the prepared mask, empties the queue and
// drops out_valid. When the receiver holds out_ready low the result stays put,
// the queue absorbs up to two more commands, then in_ready falls until the
// output moves again.
module flash_sector_prepare_guard
  import fsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_first_value,
  input  logic [31:0] in_second_value,
  input  logic [31:0] in_byte_count,
  input  logic [31:0] in_source_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_info_word,
  output logic [1:0]  out_grant_kind,
  output logic [15:0] out_grant_offset,
  output logic [16:0] out_grant_length,
  output logic [31:0] out_grant_source
);

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_full;
  logic q_not_empty;
  logic q_pop;
  logic q_push;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  fsp_front u_front (
    .action         (in_action),
    .first_value    (in_first_value),
    .second_value   (in_second_value),
    .byte_count     (in_byte_count),
    .source_address (in_source_address),
    .cmd            (front_cmd)
  );

  fsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_cmd),
    .pop       (q_pop),
    .pop_data  (q_cmd),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  fsp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (q_not_empty),
    .cmd              (q_cmd),
    .cmd_pop          (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_info_word    (out_info_word),
    .out_grant_kind   (out_grant_kind),
    .out_grant_offset (out_grant_offset),
    .out_grant_length (out_grant_length),
    .out_grant_source (out_grant_source)
  );

endmodule

[tb/fsp_checker.sv]
module fsp_checker
  import fsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_first_value,
  input  logic [31:0] in_second_value,
  input  logic [31:0] in_byte_count,
  input  logic [31:0] in_source_address,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [31:0] out_info_word,
  input  logic [1:0]  out_grant_kind,
  input  logic [15:0] out_grant_offset,
  input  logic [16:0] out_grant_length,
  input  logic [31:0] out_grant_source,
  output int          mismatches,
  output int          outstanding,
  output int          results_seen,
  output int          write_grants,
  output int          erase_grants
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] info_word;
    logic [1:0]  grant_kind;
    logic [15:0] grant_offset;
    logic [16:0] grant_length;
    logic [31:0] grant_source;
  } guard_result_t;

  logic [SECTOR_COUNT-1:0] prepared_mask;
  guard_result_t           pending_results[$];

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
    write_grants = 0;
    erase_grants = 0;
  end

  function automatic logic [SECTOR_COUNT-1:0] sector_span(logic [63:0] lo, logic [63:0] hi);
    logic [SECTOR_COUNT-1:0] span;
    span = '0;
    for (int s = 0; s < SECTOR_COUNT; s++)
      if (64'(s) >= lo && 64'(s) <= hi) span[s] = 1'b1;
    return span;
  endfunction

  function automatic bit span_valid(logic [63:0] lo, logic [63:0] hi);
    return lo < SECTOR_COUNT && hi < SECTOR_COUNT && lo <= hi;
  endfunction

  task automatic erase_sectors(input logic [63:0] lo, input logic [63:0] hi,
                               inout guard_result_t res);
    logic [SECTOR_COUNT-1:0] span;
    if (!span_valid(lo, hi)) begin
      res.status = ST_BAD_SECTOR;
    end else begin
      span = sector_span(lo, hi);
      if ((prepared_mask & span) != span) begin
        res.status = ST_NOT_PREP;
      end else begin
        prepared_mask      &= ~span;
        res.grant_kind      = GK_ERASE;
        res.grant_offset    = 16'(lo * SECTOR_BYTES);
        res.grant_length    = 17'((hi - lo + 1) * SECTOR_BYTES);
      end
    end
  endtask

  task automatic predict_command(input logic [2:0] action, input logic [31:0] first,
                                 input logic [31:0] second, input logic [31:0] count,
                                 input logic [31:0] source);
    guard_result_t           res;
    logic [63:0]             dst_end;
    logic [SECTOR_COUNT-1:0] span;
    res = '0;
    case (action)
      ACT_PREPARE: begin
        if (!span_valid(64'(first), 64'(second))) res.status = ST_BAD_SECTOR;
        else prepared_mask |= sector_span(64'(first), 64'(second));
      end
      ACT_WRITE: begin
        dst_end = 64'(first) + 64'(count);
        if (count != 256 && count != 512 && count != 1024 && count != 4096) begin
          res.status = ST_COUNT;
        end else if (first[7:0] != 8'h00) begin
          res.status = ST_ALIGN;
        end else if (dst_end > FLASH_BYTES) begin
          res.status = ST_UNMAPPED;
        end else if ((dst_end - 1) / SECTOR_BYTES >= SECTOR_COUNT) begin
          res.status = ST_NOT_PREP;
        end else begin
          span = sector_span(64'(first) / SECTOR_BYTES, (dst_end - 1) / SECTOR_BYTES);
          if ((prepared_mask & span) != span) begin
            res.status = ST_NOT_PREP;
          end else begin
            prepared_mask    &= ~span;
            res.grant_kind    = GK_WRITE;
            res.grant_offset  = first[15:0];
            res.grant_length  = count[16:0];
            res.grant_source  = source;
          end
        end
      end
      ACT_ERASE_SECT: erase_sectors(64'(first), 64'(second), res);
      ACT_ERASE_PAGES: begin
        erase_sectors((64'(first) << PAGE_SHIFT) / SECTOR_BYTES,
                      (64'(second) << PAGE_SHIFT) / SECTOR_BYTES, res);
      end
      ACT_PART_ID:  res.info_word = PART_ID_WORD;
      ACT_BOOT_VER: res.info_word = BOOT_VER_WORD;
      ACT_REINVOKE: ;
      default:      res.status = ST_BAD_CMD;
    endcase
    pending_results.push_back(res);
  endtask

  task automatic check_result(input guard_result_t got);
    guard_result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t unexpected result word: st %0d info %h kind %0d ofs %h len %h src %h",
                 $realtime, got.status, got.info_word, got.grant_kind, got.grant_offset,
                 got.grant_length, got.grant_source);
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status || got.info_word !== want.info_word ||
          got.grant_kind !== want.grant_kind || got.grant_offset !== want.grant_offset ||
          got.grant_length !== want.grant_length ||
          got.grant_source !== want.grant_source) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t mismatch: exp st %0d info %h kind %0d ofs %h len %h src %h",
                   $realtime, want.status, want.info_word, want.grant_kind,
                   want.grant_offset, want.grant_length, want.grant_source);
          $display("          got st %0d info %h kind %0d ofs %h len %h src %h",
                   got.status, got.info_word, got.grant_kind, got.grant_offset,
                   got.grant_length, got.grant_source);
        end
      end else if (got.grant_kind == GK_WRITE) begin
        write_grants++;
      end else if (got.grant_kind == GK_ERASE) begin
        erase_grants++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      prepared_mask = '0;
      pending_results.delete();
      outstanding = 0;
    end else begin
      if (in_valid && in_ready)
        predict_command(in_action, in_first_value, in_second_value, in_byte_count,
                        in_source_address);
      if (out_valid && out_ready)
        check_result({out_status, out_info_word, out_grant_kind, out_grant_offset,
                      out_grant_length, out_grant_source});
      outstanding = pending_results.size();
    end
  end

endmodule

[tb/tb.sv]
module tb
  import fsp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ACT_UNKNOWN     = 3'd7;
  localparam int         ITEMS_PER_PHASE = 200;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_action;
  logic [31:0] in_first_value;
  logic [31:0] in_second_value;
  logic [31:0] in_byte_count;
  logic [31:0] in_source_address;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [31:0] out_info_word;
  logic [1:0]  out_grant_kind;
  logic [15:0] out_grant_offset;
  logic [16:0] out_grant_length;
  logic [31:0] out_grant_source;

  int mismatches;
  int outstanding;
  int results_seen;
  int write_grants;
  int erase_grants;
  int words_sent;
  int send_idle;
  int recv_stall;

  always #4 clk = ~clk;

  flash_sector_prepare_guard u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_first_value    (in_first_value),
    .in_second_value   (in_second_value),
    .in_byte_count     (in_byte_count),
    .in_source_address (in_source_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_info_word     (out_info_word),
    .out_grant_kind    (out_grant_kind),
    .out_grant_offset  (out_grant_offset),
    .out_grant_length  (out_grant_length),
    .out_grant_source  (out_grant_source)
  );

  fsp_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_first_value    (in_first_value),
    .in_second_value   (in_second_value),
    .in_byte_count     (in_byte_count),
    .in_source_address (in_source_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_info_word     (out_info_word),
    .out_grant_kind    (out_grant_kind),
    .out_grant_offset  (out_grant_offset),
    .out_grant_length  (out_grant_length),
    .out_grant_source  (out_grant_source),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .results_seen      (results_seen),
    .write_grants      (write_grants),
    .erase_grants      (erase_grants)
  );

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall);

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input logic [2:0] action, input logic [31:0] first,
                           input logic [31:0] second, input logic [31:0] count,
                           input logic [31:0] source);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid          <= 1'b0;
      in_action         <= 3'($urandom);
      in_first_value    <= $urandom;
      in_second_value   <= $urandom;
      in_byte_count     <= $urandom;
      in_source_address <= $urandom;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= action;
    in_first_value    <= first;
    in_second_value   <= second;
    in_byte_count     <= count;
    in_source_address <= source;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic random_command;
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    logic [31:0] dst;
    logic [31:0] count;
    pick = $urandom_range(0, 99);
    if (pick < 24) begin
      lo = $urandom_range(0, SECTOR_COUNT - 1);
      hi = $urandom_range(lo, SECTOR_COUNT - 1);
      if ($urandom_range(0, 9) == 0) hi = $urandom_range(0, SECTOR_COUNT + 3);
      send_word(ACT_PREPARE, lo, hi, $urandom, $urandom);
    end else if (pick < 50) begin
      dst = $urandom_range(0, 255) << 8;
      case ($urandom_range(0, 3))
        0: count = 256;
        1: count = 512;
        2: count = 1024;
        default: count = 4096;
      endcase
      case ($urandom_range(0, 11))
        0: count = $urandom;
        1: count = count + 32'($urandom_range(0, 2)) - 1;
        2: dst = dst | 32'($urandom_range(1, 255));
        3: dst = $urandom;
        default: ;
      endcase
      send_word(ACT_WRITE, dst, $urandom, count, $urandom);
    end else if (pick < 62) begin
      lo = $urandom_range(0, SECTOR_COUNT - 1);
      hi = $urandom_range(lo, SECTOR_COUNT - 1);
      if ($urandom_range(0, 9) == 0) lo = $urandom_range(0, SECTOR_COUNT + 3);
      send_word(ACT_ERASE_SECT, lo, hi, $urandom, $urandom);
    end else if (pick < 72) begin
      lo = $urandom_range(0, 255);
      hi = $urandom_range(lo, (lo + 48 > 255) ? 255 : lo + 48);
      if ($urandom_range(0, 9) == 0) hi = $urandom;
      send_word(ACT_ERASE_PAGES, lo, hi, $urandom, $urandom);
    end else if (pick < 82) begin
      case ($urandom_range(0, 3))
        0: send_word(ACT_PART_ID, $urandom, $urandom, $urandom, $urandom);
        1: send_word(ACT_BOOT_VER, $urandom, $urandom, $urandom, $urandom);
        2: send_word(ACT_REINVOKE, $urandom, $urandom, $urandom, $urandom);
        default: send_word(ACT_UNKNOWN, $urandom, $urandom, $urandom, $urandom);
      endcase
    end else begin
      send_word(3'($urandom), $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_action         = '0;
    in_first_value    = '0;
    in_second_value   = '0;
    in_byte_count     = '0;
    in_source_address = '0;
    out_ready         = 1'b0;
    send_idle         = 0;
    recv_stall        = 0;
    words_sent        = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // info words and odd actions
    send_word(ACT_PART_ID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_BOOT_VER, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(ACT_REINVOKE, 32'h1234_5678, 32'h9ABC_DEF0, 32'd256, 32'h2000_0000);
    send_word(ACT_UNKNOWN, 32'h0, 32'hF, 32'd256, 32'h2000_0000);
    // nothing prepared yet
    send_word(ACT_WRITE, 32'h0, 32'h0, 32'd256, 32'h1000_0000);
    send_word(ACT_ERASE_SECT, 32'd0, 32'd15, 32'h0, 32'h0);
    // prepare ranges, good and bad
    send_word(ACT_PREPARE, 32'd0, 32'd15, 32'h0, 32'h0);
    send_word(ACT_PREPARE, 32'd5, 32'd4, 32'h0, 32'h0);
    send_word(ACT_PREPARE, 32'd0, 32'd16, 32'h0, 32'h0);
    send_word(ACT_PREPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    // write check order and bound without 32-bit wrap
    send_word(ACT_WRITE, 32'h0, 32'h0, 32'd0, 32'h0);
    send_word(ACT_WRITE, 32'h0000_0081, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_word(ACT_WRITE, 32'h0000_0080, 32'h0, 32'd256, 32'h0);
    send_word(ACT_WRITE, 32'hFFFF_FF00, 32'h0, 32'd4096, 32'h0);
    send_word(ACT_WRITE, 32'h0000_FF00, 32'h0, 32'd512, 32'h0);
    send_word(ACT_WRITE, 32'h0000_F000, 32'h0, 32'd4096, 32'hFFFF_FFFF);
    send_word(ACT_WRITE, 32'h0000_0F00, 32'h0, 32'd512, 32'h2000_0400);
    send_word(ACT_WRITE, 32'h0, 32'h0, 32'd1024, 32'h2000_0000);
    // page erase rounding, overflowed pages, reversed range
    send_word(ACT_ERASE_PAGES, 32'h20, 32'h2F, 32'h0, 32'h0);
    send_word(ACT_ERASE_PAGES, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_word(ACT_ERASE_PAGES, 32'h30, 32'h20, 32'h0, 32'h0);
    send_word(ACT_ERASE_SECT, 32'd3, 32'd14, 32'h0, 32'h0);
    send_word(ACT_ERASE_SECT, 32'd16, 32'd16, 32'h0, 32'h0);
    // whole flash erase gives the full 17-bit length
    send_word(ACT_PREPARE, 32'd0, 32'd15, 32'h0, 32'h0);
    send_word(ACT_ERASE_SECT, 32'd0, 32'd15, 32'h0, 32'h0);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 51; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 51; end
        default: begin send_idle = 11; recv_stall = 11; end
      endcase
      repeat (ITEMS_PER_PHASE) random_command();
      drain_results();
    end

    repeat (8) @(negedge clk);
    $display("covered %0d command words under four pacing mixes, %0d results compared",
             words_sent, results_seen);
    $display("grants seen: %0d write, %0d erase; mismatches: %0d",
             write_grants, erase_grants, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
